[rtl/core/wsup_pkg.sv]
// types, constants and character decode for the wide string to unsigned parser
`default_nettype none

package wsup_pkg;

  localparam int VALUE_WIDTH_DEF    = 64;
  localparam int POSITION_WIDTH_DEF = 16;
  localparam int CHAR_W             = 21;
  localparam int BASE_W             = 6;
  localparam int OUT_VALUE_W        = 64;
  localparam int OUT_STOP_W         = 16;
  localparam int OUT_STOP_MAX       = 65535;

  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_DEC;

  localparam logic [CHAR_W-1:0] CH_MINUS = 21'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 21'h2B;
  localparam logic [CHAR_W-1:0] CH_LX    = 21'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 21'h58;
  localparam logic [CHAR_W-1:0] CH_0     = 21'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 21'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 21'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 21'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 21'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 21'h7A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 21'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 21'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 21'h0D;
  localparam logic [BASE_W-1:0] LETTER_OFFSET = 6'd10;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              string_end;
  } char_item_t;

  typedef struct packed {
    logic [OUT_VALUE_W-1:0] value;
    logic [OUT_STOP_W-1:0]  stop_offset;
    logic                   range_error;
    logic                   digits_found;
  } result_item_t;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_EXEC = 2'b10
  } seq_state_t;

  typedef enum logic [5:0] {
    PH_SPACE  = 6'b000001,
    PH_SIGN   = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_PREFIX = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } parse_phase_t;

  typedef enum logic [2:0] {
    ST_NONE = 3'b001,
    ST_SOME = 3'b010,
    ST_OVER = 3'b100
  } digit_status_t;

  typedef struct packed {
    logic              ok;
    logic [BASE_W-1:0] val;
  } digit_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic digit_t digit_decode(input logic [CHAR_W-1:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = '0;
    if ((c >= CH_0) && (c <= CH_9)) begin
      d.val = BASE_W'(c - CH_0);
    end else if ((c >= CH_UA) && (c <= CH_UZ)) begin
      d.val = BASE_W'(c - CH_UA) + LETTER_OFFSET;
    end else if ((c >= CH_LA) && (c <= CH_LZ)) begin
      d.val = BASE_W'(c - CH_LA) + LETTER_OFFSET;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

[rtl/core/wide_string_to_unsigned_parser_top.sv]
// streaming wide string to unsigned integer parser, top level
// sequencing: each accepted character is decoded into registers and worked in
//   the EXEC state; the result is registered when the last character is worked
// input: char_stall is high outside IDLE, so a new character is taken only after
//   the previous one is worked; the multiply-add unit folds one digit per character
// stalls: a last character waits while the previous result is stalled
// reset: synchronous; clears the parse state and sets number_base to ten
`default_nettype none

module wide_string_to_unsigned_parser_top
  import wsup_pkg::*;
#(
  parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 number_base_we,
  input  wire  [BASE_W-1:0]   number_base_data,
  input  wire                 char_valid,
  output logic                char_stall,
  input  wire  char_item_t    char_item,
  output logic                result_valid,
  input  wire                 result_stall,
  output result_item_t        result_item
);

  localparam int PROD_W = VALUE_WIDTH + BASE_W;

  seq_state_t                seq;
  logic [BASE_W-1:0]         number_base;

  // decoded character
  logic [BASE_W-1:0]         dig;
  logic                      dig_ok;
  logic                      sp_c;
  logic                      minus_c;
  logic                      plus_c;
  logic                      zero_c;
  logic                      x_c;
  logic                      end_c;

  // parse state
  parse_phase_t              phase;
  parse_phase_t              phase_next;
  logic [VALUE_WIDTH-1:0]    acc;
  logic [VALUE_WIDTH-1:0]    acc_next;
  digit_status_t             status;
  digit_status_t             status_next;
  logic                      neg;
  logic                      neg_next;
  logic [BASE_W-1:0]         active_base;
  logic [BASE_W-1:0]         active_base_next;
  logic [POSITION_WIDTH-1:0] char_pos;
  logic [POSITION_WIDTH-1:0] pos_next;
  logic [POSITION_WIDTH-1:0] end_pos;
  logic [POSITION_WIDTH-1:0] end_pos_next;

  digit_t                    in_dig;
  logic                      accept;
  logic                      hold;
  logic                      load_result;
  logic                      start;
  logic                      take;
  logic [BASE_W-1:0]         nb_eff;
  logic                      nb_prefix;
  logic [BASE_W-1:0]         mul_base;
  logic [PROD_W-1:0]         prod;
  logic                      ovf;
  logic [VALUE_WIDTH-1:0]    value_fin;
  logic [OUT_STOP_W-1:0]     stop_fin;

  assign char_stall  = (seq != SEQ_IDLE);
  assign accept      = char_valid && !char_stall;
  assign in_dig      = digit_decode(char_item.char_code);
  assign hold        = end_c && result_valid && result_stall;
  assign load_result = (seq == SEQ_EXEC) && end_c && !hold;

  assign nb_eff    = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
  assign nb_prefix = (number_base == BASE_AUTO) || (number_base == BASE_HEX);
  assign mul_base  = ((phase == PH_SPACE) || (phase == PH_SIGN)) ? nb_eff : active_base;

  // shared multiply-add unit
  assign prod = PROD_W'(acc) * PROD_W'(mul_base) + PROD_W'(dig);
  assign ovf  = (prod[PROD_W-1:VALUE_WIDTH] != '0);

  assign pos_next = (char_pos == '1) ? char_pos : char_pos + 1'b1;

  always_comb begin
    phase_next       = phase;
    acc_next         = acc;
    status_next      = status;
    neg_next         = neg;
    active_base_next = active_base;
    end_pos_next     = end_pos;
    start            = 1'b0;
    take             = 1'b0;
    case (phase)
      PH_SPACE: begin
        if (sp_c) begin
          phase_next = PH_SPACE;
        end else if (minus_c) begin
          neg_next   = 1'b1;
          phase_next = PH_SIGN;
        end else if (plus_c) begin
          phase_next = PH_SIGN;
        end else begin
          start = 1'b1;
        end
      end
      PH_SIGN: begin
        start = 1'b1;
      end
      PH_ZERO: begin
        if (x_c) begin
          active_base_next = BASE_HEX;
          phase_next       = PH_PREFIX;
        end else begin
          take = 1'b1;
        end
      end
      PH_PREFIX, PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
        phase_next = phase;
      end
    endcase

    if (start) begin
      if (zero_c && nb_prefix) begin
        active_base_next = (number_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
        acc_next         = '0;
        status_next      = ST_SOME;
        end_pos_next     = pos_next;
        phase_next       = PH_ZERO;
      end else if ((nb_eff < BASE_MIN) || (nb_eff > BASE_MAX)) begin
        phase_next = PH_DONE;
      end else begin
        active_base_next = nb_eff;
        take             = 1'b1;
      end
    end

    if (take) begin
      if (!dig_ok || (dig >= mul_base)) begin
        phase_next = PH_DONE;
      end else begin
        if ((status == ST_OVER) || ovf) begin
          status_next = ST_OVER;
        end else begin
          acc_next    = prod[VALUE_WIDTH-1:0];
          status_next = ST_SOME;
        end
        end_pos_next = pos_next;
        phase_next   = PH_DIGITS;
      end
    end
  end

  always_comb begin
    if (status_next == ST_OVER) begin
      value_fin = '1;
    end else if (neg_next) begin
      value_fin = '0 - acc_next;
    end else begin
      value_fin = acc_next;
    end
    if (status_next == ST_NONE) begin
      stop_fin = '0;
    end else if (32'(end_pos_next) > 32'(OUT_STOP_MAX)) begin
      stop_fin = OUT_STOP_W'(OUT_STOP_MAX);
    end else begin
      stop_fin = OUT_STOP_W'(end_pos_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq          <= SEQ_IDLE;
      number_base  <= BASE_RESET;
      result_valid <= 1'b0;
      phase        <= PH_SPACE;
      acc          <= '0;
      status       <= ST_NONE;
      neg          <= 1'b0;
      active_base  <= '0;
      char_pos     <= '0;
      end_pos      <= '0;
      end_c        <= 1'b0;
    end else begin
      if (number_base_we) begin
        number_base <= number_base_data;
      end
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (seq)
        SEQ_IDLE: begin
          if (accept) begin
            dig     <= in_dig.val;
            dig_ok  <= in_dig.ok;
            sp_c    <= is_space(char_item.char_code);
            minus_c <= (char_item.char_code == CH_MINUS);
            plus_c  <= (char_item.char_code == CH_PLUS);
            zero_c  <= (char_item.char_code == CH_0);
            x_c     <= (char_item.char_code == CH_LX) || (char_item.char_code == CH_UX);
            end_c   <= char_item.string_end;
            seq     <= SEQ_EXEC;
          end
        end
        SEQ_EXEC: begin
          if (!hold) begin
            seq <= SEQ_IDLE;
            if (end_c) begin
              result_item.value        <= OUT_VALUE_W'(value_fin);
              result_item.stop_offset  <= stop_fin;
              result_item.range_error  <= (status_next == ST_OVER);
              result_item.digits_found <= (status_next != ST_NONE);
              phase                    <= PH_SPACE;
              acc                      <= '0;
              status                   <= ST_NONE;
              neg                      <= 1'b0;
              active_base              <= '0;
              char_pos                 <= '0;
              end_pos                  <= '0;
            end else begin
              phase       <= phase_next;
              acc         <= acc_next;
              status      <= status_next;
              neg         <= neg_next;
              active_base <= active_base_next;
              char_pos    <= pos_next;
              end_pos     <= end_pos_next;
            end
          end
        end
        default: begin
          seq <= SEQ_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/wsup_checker.sv]
// port-level assertions for the parser top level and their bind
`default_nettype none

module wsup_checker
  import wsup_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input wire               clk,
  input wire               rst,
  input wire               char_valid,
  input wire               char_stall,
  input wire               result_valid,
  input wire               result_stall,
  input wire result_item_t result_item
);

  localparam logic [OUT_VALUE_W-1:0] SAT_VALUE = OUT_VALUE_W'({VALUE_WIDTH{1'b1}});

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // one character transfer at a time
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !char_stall) |=> char_stall)
    else $error("character transfer not followed by a busy cycle");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result_item)))
    else $error("stalled result changed");

  // saturation shows all ones
  a_range_sat: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_item.range_error) |->
      (result_item.value == SAT_VALUE && result_item.digits_found))
    else $error("range error without saturated value");

  // no digits means zero value and offset
  a_no_digits: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_item.digits_found) |->
      (result_item.value == '0 && result_item.stop_offset == '0 && !result_item.range_error))
    else $error("empty parse with nonzero result");

endmodule

bind wide_string_to_unsigned_parser_top wsup_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_wsup_checker (
  .clk          (clk),
  .rst          (rst),
  .char_valid   (char_valid),
  .char_stall   (char_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);

`default_nettype wire

[tb/sv/wide_string_to_unsigned_parser_top_test.sv]
// self-checking testbench for the wide string to unsigned parser top level
`timescale 1ns / 100ps

module wide_string_to_unsigned_parser_top_test;
  import wsup_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 4;
  localparam int unsigned NOT_A_DIGIT = 99;
  localparam logic [15:0] POS_MAX = 16'hFFFF;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic number_base_we = 1'b0;
  logic [BASE_W-1:0] number_base_data = '0;
  logic char_valid = 1'b0;
  logic char_stall;
  char_item_t char_item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_item_t result_item;

  wide_string_to_unsigned_parser_top dut (
    .clk              (clk),
    .rst              (rst),
    .number_base_we   (number_base_we),
    .number_base_data (number_base_data),
    .char_valid       (char_valid),
    .char_stall       (char_stall),
    .char_item        (char_item),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result_item      (result_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // parser state mirrored by the testbench
  logic [BASE_W-1:0] base_setting = BASE_RESET;
  parse_phase_t cur_phase = PH_SPACE;
  digit_status_t cur_status = ST_NONE;
  logic [63:0] acc = '0;
  logic neg = 1'b0;
  logic [BASE_W-1:0] radix = '0;
  logic [63:0] cutoff = '0;
  logic [BASE_W-1:0] limit_digit = '0;
  logic [15:0] char_pos = '0;
  logic [15:0] end_pos = '0;

  result_item_t due_conversions[$];
  result_item_t want;

  int tx_idle_pct = 19;
  int rx_idle_pct = 48;
  int chars_sent = 0;
  int results_checked = 0;
  int overflow_results = 0;
  int empty_results = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  logic pressure_req = 1'b0;
  logic pressure_ack = 1'b0;

  function automatic logic ascii_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int unsigned digit_weight(input logic [CHAR_W-1:0] c);
    if (c >= CH_0 && c <= CH_9) return 32'(c - CH_0);
    if (c >= CH_UA && c <= CH_UZ) return 32'(c - CH_UA) + 32'(LETTER_OFFSET);
    if (c >= CH_LA && c <= CH_LZ) return 32'(c - CH_LA) + 32'(LETTER_OFFSET);
    return NOT_A_DIGIT;
  endfunction

  function automatic void clear_parse();
    cur_phase = PH_SPACE;
    cur_status = ST_NONE;
    acc = '0;
    neg = 1'b0;
    radix = '0;
    cutoff = '0;
    limit_digit = '0;
    char_pos = '0;
    end_pos = '0;
  endfunction

  function automatic void set_radix(input logic [BASE_W-1:0] b);
    radix = b;
    cutoff = ALL_ONES / 64'(b);
    limit_digit = BASE_W'(ALL_ONES % 64'(b));
  endfunction

  function automatic void add_digit(input logic [CHAR_W-1:0] c, input logic [15:0] next_pos);
    int unsigned d;
    d = digit_weight(c);
    if (radix < BASE_MIN || d >= 32'(radix)) begin
      cur_phase = PH_DONE;
    end else begin
      if (cur_status == ST_OVER || acc > cutoff || (acc == cutoff && d > 32'(limit_digit))) begin
        cur_status = ST_OVER;
      end else begin
        acc = acc * 64'(radix) + 64'(d);
        cur_status = ST_SOME;
      end
      end_pos = next_pos;
      cur_phase = PH_DIGITS;
    end
  endfunction

  function automatic void start_number(input logic [CHAR_W-1:0] c,
                                       input logic [15:0] next_pos);
    logic [BASE_W-1:0] b;
    b = base_setting;
    if (c == CH_0 && (b == BASE_AUTO || b == BASE_HEX)) begin
      set_radix((b == BASE_AUTO) ? BASE_OCT : BASE_HEX);
      acc = '0;
      cur_status = ST_SOME;
      end_pos = next_pos;
      cur_phase = PH_ZERO;
    end else begin
      if (b == BASE_AUTO) b = BASE_DEC;
      if (b < BASE_MIN || b > BASE_MAX) begin
        cur_phase = PH_DONE;
      end else begin
        set_radix(b);
        add_digit(c, next_pos);
      end
    end
  endfunction

  // advance the mirrored parser by one character, queue the conversion at string end
  function automatic void fold_char(input logic [CHAR_W-1:0] c, input logic last);
    logic [15:0] next_pos;
    result_item_t r;
    next_pos = (char_pos != POS_MAX) ? char_pos + 16'd1 : POS_MAX;
    case (cur_phase)
      PH_SPACE: begin
        if (!ascii_space(c)) begin
          if (c == CH_MINUS) begin
            neg = 1'b1;
            cur_phase = PH_SIGN;
          end else if (c == CH_PLUS) begin
            cur_phase = PH_SIGN;
          end else begin
            start_number(c, next_pos);
          end
        end
      end
      PH_SIGN: start_number(c, next_pos);
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          set_radix(BASE_HEX);
          cur_phase = PH_PREFIX;
        end else begin
          add_digit(c, next_pos);
        end
      end
      PH_PREFIX, PH_DIGITS: add_digit(c, next_pos);
      default: ;
    endcase
    char_pos = next_pos;
    if (last) begin
      if (cur_status == ST_OVER) r.value = ALL_ONES;
      else if (neg) r.value = 64'd0 - acc;
      else r.value = acc;
      r.stop_offset = (cur_status != ST_NONE) ? end_pos : '0;
      r.range_error = (cur_status == ST_OVER);
      r.digits_found = (cur_status != ST_NONE);
      due_conversions.push_back(r);
      clear_parse();
    end
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] code, input logic last);
    @(negedge clk);
    while (int'($urandom_range(99)) < tx_idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_item <= '{char_code: code, string_end: last};
    do @(posedge clk); while (char_stall);
    chars_sent++;
    fold_char(code, last);
  endtask

  task automatic send_string(input string text);
    for (int i = 0; i < text.len(); i++) begin
      send_char(CHAR_W'(text[i]), i == text.len() - 1);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    char_valid <= 1'b0;
    while (due_conversions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] b);
    settle();
    @(negedge clk);
    number_base_we <= 1'b1;
    number_base_data <= b;
    @(negedge clk);
    number_base_we <= 1'b0;
    base_setting = b;
  endtask

  function automatic logic [CHAR_W-1:0] random_code();
    if ($urandom_range(1)) return CHAR_W'($urandom_range(21'h10FFFF));
    return CHAR_W'($urandom_range(127));
  endfunction

  function automatic logic [CHAR_W-1:0] space_code();
    if ($urandom_range(5) == 0) return CH_SPACE;
    return CH_TAB + CHAR_W'($urandom_range(4));
  endfunction

  function automatic logic [CHAR_W-1:0] digit_code(input int d);
    if (d < 10) return CH_0 + CHAR_W'(d);
    return ($urandom_range(1) ? CH_UA : CH_LA) + CHAR_W'(d - 10);
  endfunction

  function automatic logic [BASE_W-1:0] random_base();
    case ($urandom_range(9))
      0: return BASE_MIN;
      1: return BASE_MAX;
      2, 3: return BASE_AUTO;
      4: return BASE_HEX;
      5: return BASE_OCT;
      6: return BASE_DEC;
      7: return $urandom_range(1) ? BASE_MIN - 6'd1 : BASE_W'($urandom_range(37, 63));
      default: return BASE_W'($urandom_range(2, 36));
    endcase
  endfunction

  // mostly well-formed numbers with random content, some noise and cut-off prefixes
  task automatic send_random_string(input logic [BASE_W-1:0] b);
    logic [CHAR_W-1:0] text[$];
    int roll;
    int digits;
    int r;
    roll = $urandom_range(99);
    r = (b >= BASE_MIN && b <= BASE_MAX) ? int'(b) : 10;
    if (roll < 12) begin
      repeat ($urandom_range(1, 5)) text.push_back(random_code());
    end else begin
      repeat ($urandom_range(0, 2)) text.push_back(space_code());
      case ($urandom_range(3))
        0: text.push_back(CH_MINUS);
        1: text.push_back(CH_PLUS);
        default: ;
      endcase
      if ((b == BASE_AUTO || b == BASE_HEX) && $urandom_range(2) == 0) begin
        text.push_back(CH_0);
        text.push_back($urandom_range(1) ? CH_LX : CH_UX);
        r = 16;
      end else if (b == BASE_AUTO && $urandom_range(3) == 0) begin
        text.push_back(CH_0);
        r = 8;
      end
      if (roll < 18) begin
        if ($urandom_range(1)) text.push_back(space_code());
      end else begin
        digits = ($urandom_range(9) == 0) ? $urandom_range(12, 70) : $urandom_range(1, 8);
        repeat (digits) begin
          text.push_back(digit_code(($urandom_range(3) == 0) ? r - 1 : $urandom_range(r - 1)));
        end
      end
      if ($urandom_range(4) == 0) text.push_back(random_code());
    end
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic test_default_base();
    tx_idle_pct = 19;
    rx_idle_pct = 48;
    send_string(" \t+42");
    send_string("-7");
    send_string("18446744073709551615");
    send_string("18446744073709551616");
    send_string("- 5");
    send_string("12a3");
    send_string("-");
    send_char(CH_0 + CHAR_W'(5), 1'b0);
    send_char('0, 1'b0);
    send_char(CH_0 + CHAR_W'(6), 1'b1);
    send_char(21'h10FFFF, 1'b1);
    send_char('0, 1'b1);
  endtask

  task automatic test_auto_and_hex_prefix();
    write_base(BASE_AUTO);
    send_string("0x1f");
    send_string("017");
    send_string("0x");
    send_string("0xg");
    send_string("-0X10");
    send_string("98");
    write_base(BASE_HEX);
    send_string("0XfF");
    send_string("fg");
    send_string("0x");
  endtask

  task automatic test_base_extremes();
    write_base(BASE_MAX);
    send_string("zZ9");
    send_string("aA@");
    send_string("-zzzzzzzzzzzzz");
    write_base(BASE_MIN);
    send_string("1012");
    write_base(BASE_MIN - 6'd1);
    send_string("1");
    write_base(BASE_MAX + 6'd1);
    send_string("1");
    write_base(6'h3F);
    send_string("0");
    write_base(BASE_OCT);
    send_string("0778");
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int item_goal);
    int first_count;
    int chunk_end;
    logic [BASE_W-1:0] b;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    first_count = chars_sent;
    while (chars_sent - first_count < item_goal) begin
      b = random_base();
      write_base(b);
      chunk_end = chars_sent + 40 + int'($urandom_range(40));
      while (chars_sent < chunk_end) send_random_string(b);
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input side stalls
  task automatic test_backpressure();
    write_base(BASE_DEC);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    pressure_req = ~pressure_req;
    repeat (12) send_string("-3");
    send_string("+65535");
  endtask

  // long run of leading zeros before the last digit
  task automatic test_long_string();
    write_base(BASE_DEC);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (40) send_char(CH_0, 1'b0);
    send_char(CH_9, 1'b1);
  endtask

  always @(negedge clk) begin
    if (pressure_req != pressure_ack) begin
      pressure_ack <= pressure_req;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= (int'($urandom_range(99)) < rx_idle_pct);
    end
  end

  task automatic compare_field(input string field, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (due_conversions.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %h",
                 $time, result_item);
        mismatches++;
      end else begin
        want = due_conversions.pop_front();
        compare_field("value", want.value, result_item.value);
        compare_field("stop_offset", 64'(want.stop_offset), 64'(result_item.stop_offset));
        compare_field("range_error", 64'(want.range_error), 64'(result_item.range_error));
        compare_field("digits_found", 64'(want.digits_found), 64'(result_item.digits_found));
        results_checked++;
        if (want.range_error) overflow_results++;
        if (!want.digits_found) empty_results++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_default_base();
    test_auto_and_hex_prefix();
    test_base_extremes();
    test_random_traffic(19, 48, 150);
    test_random_traffic(48, 19, 150);
    test_random_traffic(0, 0, 150);
    test_backpressure();
    test_long_string();
    settle();
    $display("%0d characters sent, %0d conversions checked", chars_sent, results_checked);
    $display("%0d saturated on overflow, %0d had no digits, %0d field mismatches",
             overflow_results, empty_results, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
